@@ hdl/grar_pkg.sv @@
// ----------------------------------------------------------------------------
// grar_pkg: shared definitions for the group anti-replay table
// Table geometry, window constants, status codes and sequencer states.
// ----------------------------------------------------------------------------
package grar_pkg;

  localparam int ENTRIES = 16;  // table depth, 1..31 (the occupied port is 5 bits)
  localparam int WINDOW  = 64;  // bitmap width, 1..64

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);

  localparam logic [63:0] WIN_MASK =
    (WINDOW >= 64) ? {64{1'b1}} : ((64'd1 << WINDOW) - 64'd1);
  localparam logic [63:0] WIN_SIZE = 64'(WINDOW);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_STALE   = 3'd3,
    ST_REPLAY  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_SCAN,
    S_ALLOC,
    S_EPOCH,
    S_CTR,
    S_DIST,
    S_FIN
  } state_t;

endpackage

@@ hdl/group_anti_replay_table.sv @@
// ----------------------------------------------------------------------------
// group_anti_replay_table: per-sender anti-replay table for group traffic
// Tracks (network, sender, group) triples with key epoch, highest counter
// and a sliding bitmap; checks each request and reports saturating totals.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ------------------------------------------
//  request   in_valid / in_ready   mode, is_group, network_id, sender_id,
//                                  group_id, epoch, counter
//  result    out_valid/out_ready   status, occupied, capacity_refusals,
//                                  stale_epochs, replays
//  config    cfg_wr_en             cfg_wr_data (max_counter), no wait
//
//  A check request is accepted while idle, range-checked, then scans up to
//  ENTRIES entries (the scan stops at a hit); it then allocates an entry, or
//  takes 1 to 3 epoch/counter/distance steps on the shared 64-bit subtractor,
//  and posts its result from the final step. Clear and invalid requests go
//  from the range check straight to the final step.
//  Reset (rst, synchronous) empties the table, zeroes the totals and loads
//  max_counter with all ones. in_ready is high only while idle; a result not
//  yet taken holds the sequencer in its last step.
//
module group_anti_replay_table
  import grar_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic        is_group,
  input  logic [15:0] network_id,
  input  logic [15:0] sender_id,
  input  logic [15:0] group_id,
  input  logic [31:0] epoch,
  input  logic [63:0] counter,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [4:0]  occupied,
  output logic [31:0] capacity_refusals,
  output logic [31:0] stale_epochs,
  output logic [31:0] replays
);

  // Saturating increment for the statistics totals.
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t state, state_next;

  logic [63:0] max_counter;

  // Entry table: valid bits are flops cleared on reset; the payload arrays
  // are written on allocation before they are ever read.
  logic [ENTRIES-1:0] entry_valid;
  logic [15:0]        e_net  [ENTRIES];
  logic [15:0]        e_snd  [ENTRIES];
  logic [15:0]        e_grp  [ENTRIES];
  logic [31:0]        e_epoch[ENTRIES];
  logic [63:0]        e_high [ENTRIES];
  logic [63:0]        e_win  [ENTRIES];

  logic [OCC_W-1:0]   occ;
  logic [31:0]        refusal_total;
  logic [31:0]        stale_total;
  logic [31:0]        replay_total;

  // Captured request
  logic        req_mode;
  logic        req_group;
  logic [15:0] req_net;
  logic [15:0] req_snd;
  logic [15:0] req_grp;
  logic [31:0] req_epoch;
  logic [63:0] req_ctr;

  // Scan bookkeeping
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] free_idx;
  logic             have_free;
  status_t          res;

  // --------------------------------------------------------------------------
  // Shared subtractor: every magnitude compare and distance goes through it.
  // --------------------------------------------------------------------------
  logic [63:0] alu_a, alu_b;
  logic [64:0] alu_diff;
  logic        alu_borrow;   // alu_a < alu_b
  logic        alu_zero;
  logic        alu_far;      // difference at least a full window
  logic [5:0]  alu_sh;

  always_comb begin
    alu_a = req_ctr;
    alu_b = e_high[idx];
    case (state)
      S_CHK: begin
        alu_a = max_counter;
        alu_b = req_ctr;
      end
      S_EPOCH: begin
        alu_a = {32'd0, req_epoch};
        alu_b = {32'd0, e_epoch[idx]};
      end
      S_DIST: begin
        alu_a = e_high[idx];
        alu_b = req_ctr;
      end
      default: begin
        alu_a = req_ctr;
        alu_b = e_high[idx];
      end
    endcase
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[64];
  assign alu_zero   = (alu_diff[63:0] == 64'd0);
  assign alu_far    = (alu_diff[63:0] >= WIN_SIZE);
  assign alu_sh     = alu_diff[5:0];

  logic key_hit;
  logic last_idx;
  logic out_free;

  assign key_hit  = entry_valid[idx] && (e_net[idx] == req_net) &&
                    (e_snd[idx] == req_snd) && (e_grp[idx] == req_grp);
  assign last_idx = (idx == IDX_W'(ENTRIES - 1));
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHK;
      end
      S_CHK: begin
        if (req_mode || !req_group || alu_borrow) state_next = S_FIN;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        if (key_hit) state_next = S_EPOCH;
        else if (last_idx) state_next = S_ALLOC;
      end
      S_ALLOC: state_next = S_FIN;
      S_EPOCH: begin
        if (alu_borrow || !alu_zero) state_next = S_FIN;
        else state_next = S_CTR;
      end
      S_CTR: begin
        if (!alu_borrow && !alu_zero) state_next = S_FIN;
        else state_next = S_DIST;
      end
      S_DIST: state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state: valid bits, occupancy, totals, configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_counter   <= {64{1'b1}};
      entry_valid   <= '0;
      occ           <= '0;
      refusal_total <= '0;
      stale_total   <= '0;
      replay_total  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) max_counter <= cfg_wr_data;

      // Post a new result from the final step; hold one that is not taken.
      out_valid <= (state == S_FIN && out_free) || (out_valid && !out_ready);

      case (state)
        S_CHK: begin
          if (req_mode) begin
            entry_valid <= '0;
            occ         <= '0;
          end
        end
        S_ALLOC: begin
          if (have_free) begin
            entry_valid[free_idx] <= 1'b1;
            occ                   <= occ + OCC_W'(1);
          end else begin
            refusal_total <= sat_inc(refusal_total);
          end
        end
        S_EPOCH: begin
          if (alu_borrow) stale_total <= sat_inc(stale_total);
        end
        S_DIST: begin
          if (alu_far || e_win[idx][alu_sh]) replay_total <= sat_inc(replay_total);
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath: request capture, scan pointers, entry payload, result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        // Capture the request on acceptance.
        if (in_valid) begin
          req_mode  <= mode;
          req_group <= is_group;
          req_net   <= network_id;
          req_snd   <= sender_id;
          req_grp   <= group_id;
          req_epoch <= epoch;
          req_ctr   <= counter;
        end
      end
      S_CHK: begin
        idx       <= '0;
        have_free <= 1'b0;
        if (req_mode) res <= ST_OK;
        else res <= ST_INVALID;
      end
      S_SCAN: begin
        // Remember the lowest free entry; hold idx on a hit.
        if (!entry_valid[idx] && !have_free) begin
          free_idx  <= idx;
          have_free <= 1'b1;
        end
        if (!key_hit && !last_idx) idx <= idx + IDX_W'(1);
      end
      S_ALLOC: begin
        if (have_free) begin
          e_net[free_idx]   <= req_net;
          e_snd[free_idx]   <= req_snd;
          e_grp[free_idx]   <= req_grp;
          e_epoch[free_idx] <= req_epoch;
          e_high[free_idx]  <= req_ctr;
          e_win[free_idx]   <= 64'd1;
          res               <= ST_OK;
        end else begin
          res <= ST_FULL;
        end
      end
      S_EPOCH: begin
        if (alu_borrow) begin
          res <= ST_STALE;
        end else if (!alu_zero) begin
          // Newer epoch: restart the window at this counter.
          e_epoch[idx] <= req_epoch;
          e_high[idx]  <= req_ctr;
          e_win[idx]   <= 64'd1;
          res          <= ST_OK;
        end
      end
      S_CTR: begin
        if (!alu_borrow && !alu_zero) begin
          // Higher counter: slide the bitmap and mark the new head.
          e_win[idx]  <= ((alu_far ? 64'd0 : (e_win[idx] << alu_sh)) | 64'd1) & WIN_MASK;
          e_high[idx] <= req_ctr;
          res         <= ST_OK;
        end
      end
      S_DIST: begin
        if (alu_far || e_win[idx][alu_sh]) begin
          res <= ST_REPLAY;
        end else begin
          e_win[idx] <= e_win[idx] | (64'd1 << alu_sh);
          res        <= ST_OK;
        end
      end
      S_FIN: begin
        if (out_free) begin
          status            <= res;
          occupied          <= 5'(occ);
          capacity_refusals <= refusal_total;
          stale_epochs      <= stale_total;
          replays           <= replay_total;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(occ) == $countones(entry_valid))
    else $error("occupancy count disagrees with valid bits");

  a_occ_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= ENTRIES)
    else $error("occupancy above table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in progress");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result posted outside final step");

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking testbench for group_anti_replay_table
// Feeds check and clear requests through the valid/ready request channel and
// predicts every result from a behavioral copy of the table: entry lookup
// and allocation, key epochs, the 64-bit sliding window and the saturating
// totals. max_counter is rewritten between phases while the block is idle.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import grar_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned KEY_POOL    = 20;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned SETTLE_CYC  = 30;
  localparam int          SIDE_REQ    = 0;
  localparam int          SIDE_RESULT = 1;
  localparam logic        MODE_CHECK  = 1'b0;
  localparam logic        MODE_CLEAR  = 1'b1;
  localparam logic [63:0] ALL_ONES    = {64{1'b1}};

  typedef struct {
    logic        mode;
    logic        is_group;
    logic [15:0] network;
    logic [15:0] sender;
    logic [15:0] group;
    logic [31:0] epoch;
    logic [63:0] counter;
  } request_t;

  typedef struct {
    status_t     status;
    logic [4:0]  occupied;
    logic [31:0] refusals;
    logic [31:0] stale;
    logic [31:0] replays;
  } verdict_t;

  // DUT signals; every input starts at a known value
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic        is_group = 1'b0;
  logic [15:0] network_id = '0;
  logic [15:0] sender_id = '0;
  logic [15:0] group_id = '0;
  logic [31:0] epoch = '0;
  logic [63:0] counter = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [4:0]  occupied;
  logic [31:0] capacity_refusals;
  logic [31:0] stale_epochs;
  logic [31:0] replays;

  group_anti_replay_table i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .is_group          (is_group),
    .network_id        (network_id),
    .sender_id         (sender_id),
    .group_id          (group_id),
    .epoch             (epoch),
    .counter           (counter),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .occupied          (occupied),
    .capacity_refusals (capacity_refusals),
    .stale_epochs      (stale_epochs),
    .replays           (replays)
  );

  // Shadow copy of the table, its register and the totals
  logic        tbl_valid   [ENTRIES] = '{default: 1'b0};
  logic [15:0] tbl_network [ENTRIES];
  logic [15:0] tbl_sender  [ENTRIES];
  logic [15:0] tbl_group   [ENTRIES];
  logic [31:0] tbl_epoch   [ENTRIES];
  logic [63:0] tbl_highest [ENTRIES];
  logic [63:0] tbl_window  [ENTRIES];
  logic [63:0] max_counter_q = ALL_ONES;
  logic [31:0] refusal_cnt = '0;
  logic [31:0] stale_cnt = '0;
  logic [31:0] replay_cnt = '0;

  request_t    requests_pending[$];  // filled by the sequence, drained by the driver
  verdict_t    verdicts_due[$];      // predicted results, oldest first
  request_t    req_live;             // request currently on the port
  int unsigned req_gap = 0;
  int unsigned result_stall = 0;
  int unsigned calm_left [2] = '{0, 0};
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  // Stimulus generator view of each key: its current epoch and top counter
  logic [15:0] pool_net [KEY_POOL];
  logic [15:0] pool_snd [KEY_POOL];
  logic [15:0] pool_grp [KEY_POOL];
  logic [31:0] gen_ep   [KEY_POOL];
  logic [63:0] gen_ctr  [KEY_POOL];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] bump_saturating(logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  // Apply one request to the shadow table and return the result it must give.
  function automatic verdict_t anti_replay_verdict(request_t r);
    verdict_t    v;
    int          hit;
    int          open_slot;
    int          live;
    logic [63:0] gap;
    hit = -1;
    open_slot = -1;
    live = 0;
    v.status = ST_OK;
    if (r.mode == MODE_CLEAR) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    end else if (!r.is_group || r.counter > max_counter_q) begin
      v.status = ST_INVALID;
    end else begin
      // Stop at the first matching triple; free slots seen before it count
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit < 0) begin
          if (!tbl_valid[i]) begin
            if (open_slot < 0) open_slot = i;
          end else if (tbl_network[i] == r.network && tbl_sender[i] == r.sender &&
                       tbl_group[i] == r.group) begin
            hit = i;
          end
        end
      end
      if (hit < 0) begin
        if (open_slot < 0) begin
          refusal_cnt = bump_saturating(refusal_cnt);
          v.status = ST_FULL;
        end else begin
          tbl_valid[open_slot]   = 1'b1;
          tbl_network[open_slot] = r.network;
          tbl_sender[open_slot]  = r.sender;
          tbl_group[open_slot]   = r.group;
          tbl_epoch[open_slot]   = r.epoch;
          tbl_highest[open_slot] = r.counter;
          tbl_window[open_slot]  = 64'd1;
        end
      end else if (r.epoch < tbl_epoch[hit]) begin
        stale_cnt = bump_saturating(stale_cnt);
        v.status = ST_STALE;
      end else if (r.epoch > tbl_epoch[hit]) begin
        tbl_epoch[hit]   = r.epoch;
        tbl_highest[hit] = r.counter;
        tbl_window[hit]  = 64'd1;
      end else if (r.counter > tbl_highest[hit]) begin
        // Slide forward; a jump of a whole window or more empties it
        gap = r.counter - tbl_highest[hit];
        tbl_window[hit] = (((gap >= WIN_SIZE) ? 64'd0 : (tbl_window[hit] << gap)) | 64'd1)
                          & WIN_MASK;
        tbl_highest[hit] = r.counter;
      end else begin
        gap = tbl_highest[hit] - r.counter;
        if (gap >= WIN_SIZE || ((tbl_window[hit] >> gap) & 64'd1) != 64'd0) begin
          replay_cnt = bump_saturating(replay_cnt);
          v.status = ST_REPLAY;
        end else begin
          tbl_window[hit] = tbl_window[hit] | (64'd1 << gap);
        end
      end
    end
    foreach (tbl_valid[i]) live += tbl_valid[i] ? 1 : 0;
    v.occupied = 5'(live);
    v.refusals = refusal_cnt;
    v.stale    = stale_cnt;
    v.replays  = replay_cnt;
    return v;
  endfunction

  // Wait cycles before the next request or result; now and then a calm
  // stretch with no idling at all.
  function automatic int unsigned draw_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic request_t check_req(logic [15:0] n, logic [15:0] s, logic [15:0] g,
                                          logic [31:0] ep, logic [63:0] c);
    request_t r;
    r.mode = MODE_CHECK;
    r.is_group = 1'b1;
    r.network = n;
    r.sender = s;
    r.group = g;
    r.epoch = ep;
    r.counter = c;
    return r;
  endfunction

  // Mostly well-formed traffic on a small key pool, plus clears and noise.
  function automatic request_t random_request();
    request_t    r;
    int unsigned k;
    int unsigned pick;
    r = check_req(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                  {$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r.mode = MODE_CLEAR;
      r.is_group = 1'($urandom_range(0, 1));
    end else if (pick < 9) begin
      r.is_group = 1'($urandom_range(0, 1));
    end else begin
      k = $urandom_range(0, KEY_POOL - 1);
      r.network = pool_net[k];
      r.sender = pool_snd[k];
      r.group = pool_grp[k];
      r.is_group = ($urandom_range(0, 49) != 0);
      // epoch: mostly current, sometimes newer, older or a fresh value
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        gen_ep[k] = gen_ep[k] + 32'd1;
      end else if (pick < 10) begin
        gen_ep[k] = $urandom;
      end
      r.epoch = gen_ep[k];
      if (pick >= 10 && pick < 15) r.epoch = gen_ep[k] - 32'($urandom_range(1, 3));
      // counter: small advances, in-window repeats, window edges, big jumps
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        gen_ctr[k] = gen_ctr[k] + 64'($urandom_range(1, 4));
        r.counter = gen_ctr[k];
      end else if (pick < 70) begin
        r.counter = gen_ctr[k] - 64'($urandom_range(0, 70));
      end else if (pick < 80) begin
        gen_ctr[k] = gen_ctr[k] + 64'($urandom_range(64, 5000));
        r.counter = gen_ctr[k];
      end else if (pick < 90) begin
        r.counter = gen_ctr[k] - ($urandom_range(0, 1) ? 64'd63 : 64'd64);
      end else begin
        gen_ctr[k] = gen_ctr[k] + 64'($urandom_range(5, 63));
        r.counter = gen_ctr[k];
      end
    end
    return r;
  endfunction

  // Request driver: hold each request until it is taken, then wait a drawn
  // number of cycles before presenting the next.
  always @(posedge clk) begin
    logic hold;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        verdicts_due.push_back(anti_replay_verdict(req_live));
        req_gap = draw_wait(SIDE_REQ);
      end
      if (!hold) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (requests_pending.size() > 0) begin
          req_live = requests_pending.pop_front();
          mode       <= req_live.mode;
          is_group   <= req_live.is_group;
          network_id <= req_live.network;
          sender_id  <= req_live.sender;
          group_id   <= req_live.group;
          epoch      <= req_live.epoch;
          counter    <= req_live.counter;
          hold = 1'b1;
        end
      end
      in_valid <= hold;
    end
  end

  task automatic flag_error(string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("%s", msg);
  endtask

  // Result monitor: compare every taken result with the oldest prediction,
  // then drop ready for a drawn number of cycles.
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          flag_error($sformatf("result %0d arrived with no request outstanding: st=%0d",
                               results_seen, status));
        end else begin
          want = verdicts_due.pop_front();
          if (status !== want.status || occupied !== want.occupied ||
              capacity_refusals !== want.refusals || stale_epochs !== want.stale ||
              replays !== want.replays) begin
            flag_error($sformatf({"result %0d mismatch: expected st=%0d occ=%0d ref=%0d ",
                                  "stale=%0d rep=%0d, got st=%0d occ=%0d ref=%0d ",
                                  "stale=%0d rep=%0d"},
                                 results_seen, want.status, want.occupied, want.refusals,
                                 want.stale, want.replays, status, occupied,
                                 capacity_refusals, stale_epochs, replays));
          end
        end
        result_stall = draw_wait(SIDE_RESULT);
      end
      if (result_stall > 0) begin
        result_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Write max_counter; only called while the block is idle.
  task automatic set_max_counter(logic [63:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    max_counter_q = value;
  endtask

  // Wait until every request is taken and every result checked, then let
  // the sequencer go quiet.
  task automatic settle();
    do @(negedge clk);
    while (requests_pending.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  initial begin
    request_t    r;
    logic [63:0] phase_max [4];
    int unsigned phase_len [4];

    foreach (pool_net[k]) begin
      pool_net[k] = 16'($urandom);
      pool_snd[k] = 16'($urandom);
      pool_grp[k] = 16'($urandom);
      gen_ep[k]   = $urandom;
      gen_ctr[k]  = {$urandom, $urandom};
    end
    // Keys that differ in one part of the triple only
    pool_net[1] = pool_net[0];
    pool_snd[1] = pool_snd[0];
    pool_net[2] = pool_net[0];
    pool_grp[2] = pool_grp[0];
    // Counters about to wrap, counters at zero, epochs near the top
    gen_ctr[3] = ALL_ONES - 64'd20;
    gen_ctr[4] = 64'd0;
    gen_ep[5]  = 32'hFFFF_FFFE;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: walk one entry through every window case, then fill the table
    set_max_counter(ALL_ONES);
    r = check_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, ALL_ONES);
    r.mode = MODE_CLEAR;                      // clear on an empty table
    requests_pending.push_back(r);
    r = check_req(16'h0, 16'h0, 16'h0, 32'h0, 64'd0);
    r.is_group = 1'b0;                        // not group scope: invalid
    requests_pending.push_back(r);
    requests_pending.push_back(check_req(0, 0, 0, 0, 64'd0));    // new entry
    requests_pending.push_back(check_req(0, 0, 0, 0, 64'd0));    // replay of bit 0
    requests_pending.push_back(check_req(0, 0, 0, 0, 64'd5));    // slide by 5
    requests_pending.push_back(check_req(0, 0, 0, 0, 64'd3));    // old, not yet seen
    requests_pending.push_back(check_req(0, 0, 0, 0, 64'd3));    // now a replay
    requests_pending.push_back(check_req(0, 0, 0, 0, 64'd200));  // big jump
    requests_pending.push_back(check_req(0, 0, 0, 0, 64'd136));  // one past the window
    requests_pending.push_back(check_req(0, 0, 0, 0, 64'd137));  // oldest window slot
    requests_pending.push_back(check_req(0, 0, 0, 7, 64'd10));   // newer epoch restarts
    requests_pending.push_back(check_req(0, 0, 0, 6, 64'd11));   // older epoch is stale
    requests_pending.push_back(check_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                         ALL_ONES));
    // 14 more keys fill the table; the 15th is refused
    for (int i = 1; i <= 15; i++)
      requests_pending.push_back(check_req(16'(i), 16'h00A5, 16'h5A00, 32'd1, 64'(i)));
    settle();

    // Tightest limit: only counter zero passes
    set_max_counter(64'd0);
    requests_pending.push_back(check_req(0, 0, 0, 7, 64'd1));    // above the limit
    requests_pending.push_back(check_req(0, 0, 0, 7, 64'd0));    // inside the window
    r.mode = MODE_CLEAR;
    requests_pending.push_back(r);
    settle();

    // Random phases across several limits, the extremes among them
    phase_max = '{ALL_ONES, {$urandom, $urandom}, 64'd0, ALL_ONES};
    phase_len = '{480, 240, 60, 480};
    for (int p = 0; p < 4; p++) begin
      set_max_counter(phase_max[p]);
      repeat (phase_len[p]) requests_pending.push_back(random_request());
      settle();
    end

    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/grar_pkg.sv
hdl/group_anti_replay_table.sv
tb/sv/tb.sv
